### src/sta_pkg.sv
package sta_pkg;

  localparam int unsigned AddrW = 32;
  localparam int unsigned CountW = 5;

  // Request selector codes
  typedef logic [1:0] func_t;
  localparam func_t FN_LOAD = 2'd0;
  localparam func_t FN_V2F  = 2'd1;
  localparam func_t FN_F2V  = 2'd2;

  // Result status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_NOT_FOUND = 2'd1;
  localparam status_t ST_WRITTEN   = 2'd2;

  // Configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_HEADER_SIZE  = 2'd0;
  localparam cfg_idx_t CFG_SECT_ALIGN   = 2'd1;
  localparam cfg_idx_t CFG_FILE_ALIGN   = 2'd2;
  localparam cfg_idx_t CFG_SECT_COUNT   = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } ctrl_state_e;

  typedef struct packed {
    logic [AddrW-1:0] virt_base;
    logic [AddrW-1:0] virt_size;
    logic [AddrW-1:0] raw_base;
    logic [AddrW-1:0] raw_size;
  } sect_entry_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic scan;
    logic emit;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic needs_scan;
    logic hit;
    logic done;
    logic out_free;
  } dp_stat_t;

endpackage

### src/sta_ctrl.sv
module sta_ctrl
  import sta_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = stat_i.needs_scan ? ST_SCAN : ST_RESP;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.hit || stat_i.done) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

### src/sta_dp.sv
module sta_dp
  import sta_pkg::*;
#(
  parameter int unsigned MAX_SECTIONS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  cfg_idx_t         cfg_index_i,
  input  logic [AddrW-1:0] cfg_data_i,
  input  func_t            func_i,
  input  logic [3:0]       entry_index_i,
  input  logic [AddrW-1:0] virt_base_i,
  input  logic [AddrW-1:0] virt_size_i,
  input  logic [AddrW-1:0] raw_base_i,
  input  logic [AddrW-1:0] raw_size_i,
  input  logic [AddrW-1:0] query_address_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [AddrW-1:0] translated_address_o,
  output status_t          status_o,
  input  ctrl_cmd_t        cmd_i,
  output dp_stat_t         stat_o
);

  localparam int unsigned IdxW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int unsigned PtrW = $clog2(MAX_SECTIONS + 1);

  logic [AddrW-1:0]  header_size_q, sect_align_q, file_align_q;
  logic [CountW-1:0] sect_count_q;

  sect_entry_t       mem [MAX_SECTIONS];
  sect_entry_t       rdata_q;
  logic              rd_vld_q;
  logic              rd_en;
  logic [PtrW-1:0]   ptr_q, lim_q, lim_d;
  logic [AddrW-1:0]  addr_q;
  logic              dir_f2v_q;

  logic [AddrW-1:0]  res_q, res_d;
  status_t           st_q, st_d;
  logic              out_valid_q;
  logic [AddrW-1:0]  out_addr_q;
  status_t           out_st_q;

  logic              is_query, bypass, idx_ok, match;
  logic [31:0]       idx_ext;
  logic [AddrW-1:0]  m_base, m_size, o_base, m_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_size_q <= '0;
      sect_align_q  <= '0;
      file_align_q  <= '0;
      sect_count_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_HEADER_SIZE: header_size_q <= cfg_data_i;
        CFG_SECT_ALIGN:  sect_align_q  <= cfg_data_i;
        CFG_FILE_ALIGN:  file_align_q  <= cfg_data_i;
        CFG_SECT_COUNT:  sect_count_q  <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  assign is_query = (func_i == FN_V2F) || (func_i == FN_F2V);
  assign bypass   = (query_address_i < header_size_q) || (sect_align_q == file_align_q);
  assign idx_ext  = 32'(entry_index_i);
  assign idx_ok   = idx_ext < 32'(MAX_SECTIONS);
  assign lim_d    = (32'(sect_count_q) > 32'(MAX_SECTIONS)) ? PtrW'(MAX_SECTIONS)
                                                            : PtrW'(sect_count_q);

  // Section table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && (func_i == FN_LOAD) && idx_ok) begin
      mem[idx_ext[IdxW-1:0]] <= '{virt_base: virt_base_i, virt_size: virt_size_i,
                                  raw_base: raw_base_i, raw_size: raw_size_i};
    end
    if (rd_en) begin
      rdata_q <= mem[ptr_q[IdxW-1:0]];
    end
  end

  assign rd_en = cmd_i.scan && (ptr_q < lim_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      ptr_q    <= '0;
    end else begin
      rd_vld_q <= rd_en;
      if (cmd_i.accept) begin
        ptr_q <= '0;
      end else if (rd_en) begin
        ptr_q <= ptr_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      addr_q    <= query_address_i;
      dir_f2v_q <= (func_i == FN_F2V);
      lim_q     <= lim_d;
    end
  end

  assign m_base = dir_f2v_q ? rdata_q.raw_base  : rdata_q.virt_base;
  assign m_size = dir_f2v_q ? rdata_q.raw_size  : rdata_q.virt_size;
  assign o_base = dir_f2v_q ? rdata_q.virt_base : rdata_q.raw_base;
  assign m_end  = m_base + m_size;
  assign match  = (addr_q >= m_base) && (addr_q < m_end);

  always_comb begin
    res_d = res_q;
    st_d  = st_q;
    if (cmd_i.accept) begin
      res_d = '0;
      st_d  = ST_NOT_FOUND;
      if (func_i == FN_LOAD) begin
        st_d = ST_WRITTEN;
      end else if (is_query && bypass) begin
        res_d = query_address_i;
        st_d  = ST_OK;
      end
    end else if (cmd_i.scan && rd_vld_q && match) begin
      res_d = o_base + (addr_q - m_base);
      st_d  = ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    st_q  <= st_d;
  end

  // Output register: hold a finished result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_addr_q <= res_q;
      out_st_q   <= st_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign translated_address_o = out_addr_q;
  assign status_o             = out_st_q;

  assign stat_o.needs_scan = is_query && !bypass;
  assign stat_o.hit        = rd_vld_q && match;
  assign stat_o.done       = !rd_vld_q && (ptr_q >= lim_q);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

endmodule

### src/section_table_address_translator.sv
// Section table address translator. Keeps a table of up to MAX_SECTIONS image
// sections (virtual base/size, raw base/size) and translates addresses between
// virtual and file-offset space; the first matching section in table order
// wins, and sums wrap at 32 bits. Addresses below header_size, or any address
// when section_alignment equals file_alignment, pass through unchanged. A
// request with func 0 writes one table entry (status 2); func 1 and 2 translate
// (status 0 on a hit, 1 with address 0 on a miss); func 3 answers not found.
// Timing: one request at a time. Loads and pass-through queries go from
// acceptance through the result register to the output register; a table
// search reads at most N = min(section_count, MAX_SECTIONS) entries and stops
// at the first match, through the single read port of the section table,
// one entry per cycle with a registered read. A result that cannot leave
// the output register holds back the next result while it waits. A new
// request is accepted while the previous result still waits in the output
// register. Entries must be loaded before a search reaches them. Configuration
// must be written only while the block is idle; the block does not enforce it.
module section_table_address_translator
  import sta_pkg::*;
#(
  parameter int unsigned MAX_SECTIONS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [3:0]  entry_index_i,
  input  logic [31:0] virt_base_i,
  input  logic [31:0] virt_size_i,
  input  logic [31:0] raw_base_i,
  input  logic [31:0] raw_size_i,
  input  logic [31:0] query_address_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] translated_address_o,
  output logic [1:0]  status_o
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Sequence each request: accept, scan the table if needed, deliver
  sta_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Hold config, section table, match logic and the output register
  sta_dp #(
    .MAX_SECTIONS (MAX_SECTIONS)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .func_i               (func_i),
    .entry_index_i        (entry_index_i),
    .virt_base_i          (virt_base_i),
    .virt_size_i          (virt_size_i),
    .raw_base_i           (raw_base_i),
    .raw_size_i           (raw_size_i),
    .query_address_i      (query_address_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .translated_address_o (translated_address_o),
    .status_o             (status_o),
    .cmd_i                (cmd),
    .stat_o               (stat)
  );

endmodule

### bench/section_table_address_translator_tb.sv
`timescale 1ns / 100ps

module section_table_address_translator_tb;
  import sta_pkg::*;

  localparam int unsigned TableDepth = 16;
  localparam int unsigned PhaseCount = 10;
  localparam int unsigned PhaseItems = 155;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned MaxPrinted = 40;

  // Selector code 3 has no name in the package; it must answer not found.
  localparam func_t FN_UNUSED = 2'd3;

  typedef struct packed {
    logic [31:0] addr;
    status_t     status;
  } translation_t;

  typedef struct {
    translation_t result;
    int unsigned  seq;
  } pending_entry_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  cfg_idx_t    cfg_index_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  func_t       func_i;
  logic [3:0]  entry_index_i;
  logic [31:0] virt_base_i;
  logic [31:0] virt_size_i;
  logic [31:0] raw_base_i;
  logic [31:0] raw_size_i;
  logic [31:0] query_address_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] translated_address_o;
  status_t     status_o;

  section_table_address_translator #(
    .MAX_SECTIONS(TableDepth)
  ) dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .func_i              (func_i),
    .entry_index_i       (entry_index_i),
    .virt_base_i         (virt_base_i),
    .virt_size_i         (virt_size_i),
    .raw_base_i          (raw_base_i),
    .raw_size_i          (raw_size_i),
    .query_address_i     (query_address_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .translated_address_o(translated_address_o),
    .status_o            (status_o)
  );

  // 12 ns period: 6 high, 6 low.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the section table and the settings registers. The table is
  // updated when a load request is accepted; the registers when written.
  // ---------------------------------------------------------------------------
  logic [31:0] tbl_virt_base [TableDepth];
  logic [31:0] tbl_virt_size [TableDepth];
  logic [31:0] tbl_raw_base  [TableDepth];
  logic [31:0] tbl_raw_size  [TableDepth];
  logic        entry_loaded  [TableDepth];

  logic [31:0] cfg_header_size;
  logic [31:0] cfg_sect_align;
  logic [31:0] cfg_file_align;
  logic [4:0]  cfg_sect_count;

  pending_entry_t pending_translations[$];

  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned request_count;
  int unsigned load_count;
  int unsigned query_count;
  int unsigned unused_count;
  int unsigned settings_count;
  int unsigned seen_ok;
  int unsigned seen_not_found;
  int unsigned seen_written;
  int unsigned hold_cycles;
  bit          calm;

  function automatic int unsigned searched_entries();
    return (cfg_sect_count > TableDepth) ? TableDepth : int'(cfg_sect_count);
  endfunction

  // Work out the answer to one request and apply a load to the shadow table.
  function automatic translation_t predict_translation(func_t f, logic [3:0] idx,
                                                       logic [31:0] vb, logic [31:0] vs,
                                                       logic [31:0] rb, logic [31:0] rs,
                                                       logic [31:0] qa);
    translation_t r;
    int unsigned  i;
    bit           found;
    logic [31:0]  mb;
    logic [31:0]  ms;
    logic [31:0]  ob;
    logic [31:0]  range_end;
    r.addr   = '0;
    r.status = ST_NOT_FOUND;
    found    = 1'b0;
    if (f == FN_LOAD) begin
      tbl_virt_base[idx] = vb;
      tbl_virt_size[idx] = vs;
      tbl_raw_base[idx]  = rb;
      tbl_raw_size[idx]  = rs;
      entry_loaded[idx]  = 1'b1;
      r.status           = ST_WRITTEN;
    end else if (f == FN_V2F || f == FN_F2V) begin
      if (qa < cfg_header_size || cfg_sect_align == cfg_file_align) begin
        // Headers, and identical alignments, map onto themselves.
        r.addr = qa;
        found  = 1'b1;
      end else begin
        for (i = 0; i < searched_entries(); i++) begin
          if (!found) begin
            if (f == FN_V2F) begin
              mb = tbl_virt_base[i];
              ms = tbl_virt_size[i];
              ob = tbl_raw_base[i];
            end else begin
              mb = tbl_raw_base[i];
              ms = tbl_raw_size[i];
              ob = tbl_virt_base[i];
            end
            // The end wraps at 32 bits, so a section running past the top
            // matches nothing.
            range_end = mb + ms;
            if (qa >= mb && qa < range_end) begin
              r.addr = ob + qa - mb;
              found  = 1'b1;
            end
          end
        end
      end
      r.status = found ? ST_OK : ST_NOT_FOUND;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Reporting
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MaxPrinted) $display("MISMATCH: %s", msg);
  endtask

  task automatic check_result(logic [31:0] got_addr, status_t got_status);
    pending_entry_t want;
    case (got_status)
      ST_OK:        seen_ok++;
      ST_NOT_FOUND: seen_not_found++;
      ST_WRITTEN:   seen_written++;
      default:      ;
    endcase
    if (pending_translations.size() == 0) begin
      flag_mismatch($sformatf("result with nothing pending: addr %h status %0d",
                              got_addr, got_status));
    end else begin
      want = pending_translations.pop_front();
      if (got_status !== want.result.status)
        flag_mismatch($sformatf("request %0d: status %0d, want %0d",
                                want.seq, got_status, want.result.status));
      if (got_addr !== want.result.addr)
        flag_mismatch($sformatf("request %0d: address %h, want %h",
                                want.seq, got_addr, want.result.addr));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------
  function automatic int unsigned draw_gap();
    return calm ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic logic [31:0] random_base();
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return 32'hFFFF_FFFF - $urandom_range(0, 32'h3000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] random_size(logic [31:0] base);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom;
      3:       return ~base + 32'd1;  // end lands exactly on the wrap
      default: return $urandom_range(1, 32'h4000);
    endcase
  endfunction

  // Mostly aim inside or at the edges of a searched section; some noise.
  function automatic logic [31:0] pick_query_address(func_t f);
    int unsigned kind;
    int unsigned j;
    logic [31:0] base;
    logic [31:0] size;
    kind = $urandom_range(0, 19);
    if (searched_entries() != 0 && kind < 14) begin
      j    = $urandom_range(0, searched_entries() - 1);
      base = (f == FN_V2F) ? tbl_virt_base[j] : tbl_raw_base[j];
      size = (f == FN_V2F) ? tbl_virt_size[j] : tbl_raw_size[j];
      if (kind < 10) return base + ((size == 0) ? 32'd0 : ($urandom % size));
      case (kind)
        10:      return base;
        11:      return base + size - 32'd1;
        12:      return base + size;
        default: return base - 32'd1;
      endcase
    end
    if (kind < 17 && cfg_header_size != 0) return $urandom % cfg_header_size;
    return $urandom;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  task automatic send_request(func_t f, logic [3:0] idx, logic [31:0] vb,
                              logic [31:0] vs, logic [31:0] rb, logic [31:0] rs,
                              logic [31:0] qa);
    int unsigned    gap;
    pending_entry_t want;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    // Hold valid and payload until the handshake completes.
    in_valid_i      <= 1'b1;
    func_i          <= f;
    entry_index_i   <= idx;
    virt_base_i     <= vb;
    virt_size_i     <= vs;
    raw_base_i      <= rb;
    raw_size_i      <= rs;
    query_address_i <= qa;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    want.result = predict_translation(f, idx, vb, vs, rb, rs, qa);
    want.seq    = request_count;
    pending_translations.push_back(want);
    request_count++;
    case (f)
      FN_LOAD:   load_count++;
      FN_UNUSED: unused_count++;
      default:   query_count++;
    endcase
  endtask

  // Query fields are noise on a load and vice versa.
  task automatic send_load(logic [3:0] idx, logic [31:0] vb, logic [31:0] vs,
                           logic [31:0] rb, logic [31:0] rs);
    send_request(FN_LOAD, idx, vb, vs, rb, rs, $urandom);
  endtask

  task automatic send_query(func_t f, logic [31:0] qa);
    send_request(f, 4'($urandom), $urandom, $urandom, $urandom, $urandom, qa);
  endtask

  task automatic load_random_entry(logic [3:0] idx);
    logic [31:0] vb;
    logic [31:0] rb;
    vb = random_base();
    rb = random_base();
    send_load(idx, vb, random_size(vb), rb, random_size(rb));
  endtask

  // Drop valid and let every pending result drain.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_translations.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Settings registers; written only while the block is idle.
  // ---------------------------------------------------------------------------
  task automatic write_register(cfg_idx_t idx, logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    case (idx)
      CFG_HEADER_SIZE: cfg_header_size = data;
      CFG_SECT_ALIGN:  cfg_sect_align  = data;
      CFG_FILE_ALIGN:  cfg_file_align  = data;
      CFG_SECT_COUNT:  cfg_sect_count  = data[4:0];
      default:         ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic program_settings(logic [31:0] hs, logic [31:0] sa, logic [31:0] fa,
                                  logic [31:0] cnt_word);
    write_register(CFG_HEADER_SIZE, hs);
    write_register(CFG_SECT_ALIGN, sa);
    write_register(CFG_FILE_ALIGN, fa);
    write_register(CFG_SECT_COUNT, cnt_word);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    settings_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: stall ready for a drawn number of valid cycles per result.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_cycles  = 0;
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        check_result(translated_address_o, status_o);
        hold_cycles = draw_gap();
      end else if (out_valid_o && hold_cycles != 0) begin
        hold_cycles--;
      end
      out_ready_i <= (hold_cycles == 0);
    end
  end

  always @(posedge clk_i) cycle_count++;

  initial begin
    while (cycle_count < CycleLimit) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d results pending", cycle_count,
             pending_translations.size());
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Out of reset both alignments are zero, so every query maps onto itself.
  task automatic test_identity_after_reset();
    send_query(FN_V2F, 32'hFFFF_FFFF);
    send_query(FN_F2V, 32'h0000_0000);
    send_query(FN_UNUSED, 32'h1234_5678);
  endtask

  // Hand-built sections: overlap where the first one wins, wrapping ends,
  // a zero-size raw range, header pass-through, and the count edge cases.
  task automatic test_directed_sections();
    wait_idle();
    program_settings(32'h400, 32'h1000, 32'h200, 32'd4);
    send_load(4'd0, 32'h0000_1000, 32'h2000, 32'h0000_0400, 32'h1800);
    send_load(4'd1, 32'h0000_2000, 32'h2000, 32'h0000_3000, 32'h1000);
    send_load(4'd2, 32'hFFFF_F000, 32'h1000, 32'hFFFF_FFFF, 32'h1);
    send_load(4'd3, 32'h0000_8000, 32'h0100, 32'h0000_0000, 32'h0);
    send_load(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_query(FN_V2F, 32'h0000_03FF);
    send_query(FN_V2F, 32'h0000_0400);
    send_query(FN_V2F, 32'h0000_1000);
    send_query(FN_V2F, 32'h0000_2FFF);
    send_query(FN_V2F, 32'h0000_3000);
    send_query(FN_V2F, 32'hFFFF_F800);
    send_query(FN_V2F, 32'h0000_8010);
    send_query(FN_F2V, 32'h0000_0400);
    send_query(FN_F2V, 32'h0000_1BFF);
    send_query(FN_F2V, 32'h0000_3000);
    send_query(FN_F2V, 32'hFFFF_FFFF);
    send_query(FN_UNUSED, 32'hDEAD_BEEF);
    // Empty search range.
    wait_idle();
    program_settings(32'h400, 32'h1000, 32'h200, 32'd0);
    send_query(FN_V2F, 32'h0000_1000);
    // Equal alignments bypass the table.
    wait_idle();
    program_settings(32'h400, 32'h200, 32'h200, 32'd4);
    send_query(FN_F2V, 32'hABCD_EF01);
    // Largest header: only the top address reaches the table.
    wait_idle();
    program_settings(32'hFFFF_FFFF, 32'h1000, 32'h200, 32'd4);
    send_query(FN_V2F, 32'hFFFF_FFFE);
    send_query(FN_V2F, 32'hFFFF_FFFF);
  endtask

  // Phases of random traffic, each under its own register settings.
  task automatic test_random_mix();
    int unsigned phase;
    int unsigned sent;
    int unsigned i;
    int unsigned pick;
    logic [31:0] hs;
    logic [31:0] sa;
    logic [31:0] fa;
    logic [31:0] cnt_word;
    for (phase = 0; phase < PhaseCount; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          hs = '0; sa = 32'h1000; fa = 32'h200; cnt_word = 32'd16;
        end
        1: begin
          // Count above the table size, with junk in the upper data bits.
          hs = '1; sa = '1; fa = '0; cnt_word = {27'($urandom), 5'd31};
        end
        2: begin
          hs = $urandom_range(0, 32'h1000); sa = $urandom; fa = sa;
          cnt_word = $urandom_range(1, 16);
        end
        3: begin
          hs = '0; sa = '0; fa = '1; cnt_word = 32'd0;
        end
        4: begin
          hs = $urandom; sa = $urandom; fa = $urandom; cnt_word = 32'd17;
        end
        default: begin
          case ($urandom_range(0, 5))
            0:       hs = '0;
            1:       hs = $urandom;
            2:       hs = '1;
            default: hs = $urandom_range(0, 32'hFFFF);
          endcase
          sa = $urandom;
          fa = ($urandom_range(0, 4) == 0) ? sa : $urandom;
          cnt_word = {27'($urandom), 5'(($urandom_range(0, 3) == 0) ?
                                       $urandom_range(0, 31) : $urandom_range(1, 16))};
        end
      endcase
      program_settings(hs, sa, fa, cnt_word);
      // Run some phases with no idling on either side.
      calm = (phase % 4 == 3);
      sent = 0;
      // Fill every searched entry before any query can reach it.
      for (i = 0; i < searched_entries(); i++) begin
        if (!entry_loaded[i]) begin
          load_random_entry(4'(i));
          sent++;
        end
      end
      while (sent < PhaseItems) begin
        // Pause mid-phase, and now and then at random, until the block has answered everything.
        if (sent == PhaseItems / 2 || $urandom_range(0, 49) == 0) wait_idle();
        pick = $urandom_range(0, 99);
        if (pick < 22) begin
          load_random_entry(4'($urandom_range(0, TableDepth - 1)));
        end else if (pick < 96) begin
          if (pick % 2 == 0) send_query(FN_V2F, pick_query_address(FN_V2F));
          else send_query(FN_F2V, pick_query_address(FN_F2V));
        end else begin
          send_query(FN_UNUSED, $urandom);
        end
        sent++;
      end
      calm = 1'b0;
    end
  endtask

  initial begin
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_index_i     <= CFG_HEADER_SIZE;
    cfg_data_i      <= '0;
    in_valid_i      <= 1'b0;
    func_i          <= FN_LOAD;
    entry_index_i   <= '0;
    virt_base_i     <= '0;
    virt_size_i     <= '0;
    raw_base_i      <= '0;
    raw_size_i      <= '0;
    query_address_i <= '0;
    calm            = 1'b0;
    cfg_header_size = '0;
    cfg_sect_align  = '0;
    cfg_file_align  = '0;
    cfg_sect_count  = '0;
    for (int k = 0; k < TableDepth; k++) entry_loaded[k] = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_identity_after_reset();
    test_directed_sections();
    test_random_mix();

    // Drain, then give the block time to show any stray result.
    wait_idle();
    repeat (50) @(posedge clk_i);
    if (pending_translations.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", pending_translations.size()));

    $display("Covered %0d requests (%0d loads, %0d queries, %0d unused selector) under %0d settings",
             request_count, load_count, query_count, unused_count, settings_count);
    $display("Results: %0d translated, %0d not found, %0d written; %0d mismatches",
             seen_ok, seen_not_found, seen_written, mismatch_count);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
src/sta_pkg.sv
src/sta_ctrl.sv
src/sta_dp.sv
src/section_table_address_translator.sv
bench/section_table_address_translator_tb.sv
